>>> src/qdd_pkg.sv
// shared constants, types and helpers for the quadrature detent decoder
package qdd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int SPD_WIDTH = 4;
   localparam int INTERVAL_WIDTH = 16;
   localparam int ACC_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic {
      CSR_STEPS_PER_DETENT = 1'b0,
      CSR_SAMPLE_INTERVAL  = 1'b1
   } csr_index_type;

   typedef logic signed [COUNT_WIDTH-1:0] count_type;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;
   typedef logic signed [1:0] step_type;

   localparam logic [SPD_WIDTH-1:0] SPD_RESET = SPD_WIDTH'(4);
   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1);

   localparam count_type COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam count_type COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // indexed by {previous ab, current ab}
   localparam step_type STEP_TABLE [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

   // low field bits of the count, sign-extended when the count is narrower
   function automatic logic [FIELD_WIDTH-1:0] to_field(input count_type value);
      logic [COUNT_WIDTH+FIELD_WIDTH-1:0] wide;
      wide = {{FIELD_WIDTH{value[COUNT_WIDTH-1]}}, value};
      return wide[FIELD_WIDTH-1:0];
   endfunction

endpackage

>>> src/qdd_req_if.sv
// request channel: timer tick, pin levels and take request
interface qdd_req_if;
   logic valid;
   logic ready;
   logic ms_tick;
   logic level_a;
   logic level_b;
   logic take_request;

   modport source (output valid, output ms_tick, output level_a, output level_b,
                   output take_request, input ready);
   modport sink (input valid, input ms_tick, input level_a, input level_b,
                 input take_request, output ready);
endinterface

>>> src/qdd_rsp_if.sv
// response channel: turns handed out and pending count
interface qdd_rsp_if;
   logic valid;
   logic ready;
   logic signed [qdd_pkg::FIELD_WIDTH-1:0] turns_taken;
   logic signed [qdd_pkg::FIELD_WIDTH-1:0] pending_now;

   modport source (output valid, output turns_taken, output pending_now, input ready);
   modport sink (input valid, input turns_taken, input pending_now, output ready);
endinterface

>>> src/quadrature_detent_decoder_unit.sv
// quadrature detent decoder: x4 gray decoding, detent accumulation, take and clear
//
//   channel   dir  handshake           payload
//   req_chan  in   valid/ready         ms_tick, level_a, level_b, take_request
//   rsp_chan  out  valid/ready         turns_taken, pending_now
//   csr_*     in   csr_we only         csr_index, csr_wdata
//
// one transaction per cycle unless stalled; a response follows in the next cycle
// decoder state and the response register update in the accept cycle
// req_chan.ready is low only while a response is held and rsp_chan.ready is low
// synchronous active-high reset; no clearing pass, ready right after reset
module quadrature_detent_decoder_unit (
   input  logic clock,
   input  logic reset,
   qdd_req_if.sink req_chan,
   qdd_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  qdd_pkg::csr_index_type csr_index,
   input  logic [qdd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [qdd_pkg::SPD_WIDTH-1:0] spd_ff;
   logic [qdd_pkg::INTERVAL_WIDTH-1:0] interval_ff;
   logic primed_ff, primed_in;
   logic [1:0] prev_ab_ff, prev_ab_in;
   qdd_pkg::acc_type acc_ff, acc_in;
   qdd_pkg::count_type count_ff, count_in;
   logic [qdd_pkg::INTERVAL_WIDTH-1:0] ticks_ff, ticks_in;
   logic rsp_valid_ff;
   logic [qdd_pkg::FIELD_WIDTH-1:0] turns_ff, turns_in;
   logic [qdd_pkg::FIELD_WIDTH-1:0] pending_ff, pending_in;

   logic accept;
   logic do_sample;
   logic [1:0] ab;
   logic [qdd_pkg::INTERVAL_WIDTH-1:0] interval_eff;
   logic [qdd_pkg::INTERVAL_WIDTH-1:0] ticks_inc;
   qdd_pkg::acc_type spd_eff;
   qdd_pkg::acc_type acc_sum;
   qdd_pkg::count_type count_after;
   qdd_pkg::count_type taken;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign ab = {req_chan.level_a, req_chan.level_b};

   always_comb begin
      interval_eff = (interval_ff == '0) ? qdd_pkg::INTERVAL_WIDTH'(1) : interval_ff;
      ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + qdd_pkg::INTERVAL_WIDTH'(1);
      do_sample = req_chan.ms_tick && (ticks_inc >= interval_eff);
      if (!req_chan.ms_tick) begin
         ticks_in = ticks_ff;
      end else if (do_sample) begin
         ticks_in = '0;
      end else begin
         ticks_in = ticks_inc;
      end

      spd_eff = (spd_ff == '0) ? qdd_pkg::acc_type'(1)
                               : qdd_pkg::acc_type'({1'b0, spd_ff});
      acc_sum = acc_ff + qdd_pkg::acc_type'(qdd_pkg::STEP_TABLE[{prev_ab_ff, ab}]);

      primed_in = primed_ff;
      prev_ab_in = prev_ab_ff;
      acc_in = acc_ff;
      count_after = count_ff;
      if (do_sample) begin
         primed_in = 1'b1;
         prev_ab_in = ab;
         if (primed_ff) begin
            if (acc_sum >= spd_eff) begin
               acc_in = acc_sum - spd_eff;
               if (count_ff != qdd_pkg::COUNT_MAX) begin
                  count_after = count_ff + qdd_pkg::count_type'(1);
               end
            end else if (acc_sum <= -spd_eff) begin
               acc_in = acc_sum + spd_eff;
               if (count_ff != qdd_pkg::COUNT_MIN) begin
                  count_after = count_ff - qdd_pkg::count_type'(1);
               end
            end else begin
               acc_in = acc_sum;
            end
         end
      end

      if (req_chan.take_request) begin
         taken = count_after;
         count_in = '0;
      end else begin
         taken = '0;
         count_in = count_after;
      end
      turns_in = qdd_pkg::to_field(taken);
      pending_in = qdd_pkg::to_field(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_ff <= qdd_pkg::SPD_RESET;
         interval_ff <= qdd_pkg::INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            qdd_pkg::CSR_STEPS_PER_DETENT: spd_ff <= csr_wdata[qdd_pkg::SPD_WIDTH-1:0];
            qdd_pkg::CSR_SAMPLE_INTERVAL: begin
               interval_ff <= csr_wdata[qdd_pkg::INTERVAL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         prev_ab_ff <= '0;
         acc_ff <= '0;
         count_ff <= '0;
         ticks_ff <= '0;
      end else if (accept) begin
         primed_ff <= primed_in;
         prev_ab_ff <= prev_ab_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         turns_ff <= turns_in;
         pending_ff <= pending_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.turns_taken = turns_ff;
   assign rsp_chan.pending_now = pending_ff;

endmodule

>>> tb/qdd_turn_checker.sv
// checker for the quadrature detent decoder: watches channels, predicts turn reports, compares
`timescale 1ns / 100ps

module qdd_turn_checker (
   input  logic clock,
   input  logic reset,
   qdd_req_if req_mon,
   qdd_rsp_if rsp_mon,
   input  logic csr_we,
   input  qdd_pkg::csr_index_type csr_index,
   input  logic [qdd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output int failures,
   output int awaiting
);

   typedef struct packed {
      logic signed [qdd_pkg::FIELD_WIDTH-1:0] turns_taken;
      logic signed [qdd_pkg::FIELD_WIDTH-1:0] pending_now;
   } turn_report_type;

   localparam qdd_pkg::count_type TURN_CEILING = {1'b0, {(qdd_pkg::COUNT_WIDTH-1){1'b1}}};
   localparam qdd_pkg::count_type TURN_FLOOR = {1'b1, {(qdd_pkg::COUNT_WIDTH-1){1'b0}}};

   logic [qdd_pkg::SPD_WIDTH-1:0] detent_size;
   logic [qdd_pkg::INTERVAL_WIDTH-1:0] tick_interval;
   logic primed;
   logic [1:0] last_ab;
   qdd_pkg::acc_type step_sum;
   qdd_pkg::count_type turn_count;
   logic [15:0] tick_count;
   turn_report_type expected_reports[$];
   int mismatch_count = 0;

   assign failures = mismatch_count;

   function automatic logic [1:0] gray_position(input logic [1:0] ab);
      case (ab)
         2'b00: return 2'd0;
         2'b10: return 2'd1;
         2'b11: return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   task automatic sample_pins(input logic [1:0] ab);
      int spd;
      int sum;
      logic [1:0] delta;
      spd = (detent_size == '0) ? 1 : int'(detent_size);
      if (!primed) begin
         primed = 1'b1;
         last_ab = ab;
      end else begin
         delta = gray_position(ab) - gray_position(last_ab);
         sum = int'(step_sum);
         if (delta == 2'd1) sum = sum + 1;
         else if (delta == 2'd3) sum = sum - 1;
         last_ab = ab;
         if (sum >= spd) begin
            if (turn_count != TURN_CEILING) begin
               turn_count = turn_count + qdd_pkg::count_type'(1);
            end
            sum = sum - spd;
         end else if (sum <= -spd) begin
            if (turn_count != TURN_FLOOR) begin
               turn_count = turn_count - qdd_pkg::count_type'(1);
            end
            sum = sum + spd;
         end
         step_sum = qdd_pkg::acc_type'(sum);
      end
   endtask

   task automatic predict_turn_report(input logic tick, input logic a, input logic b,
                                      input logic take, output turn_report_type report);
      logic [qdd_pkg::INTERVAL_WIDTH-1:0] limit;
      limit = (tick_interval == '0) ? qdd_pkg::INTERVAL_WIDTH'(1) : tick_interval;
      report.turns_taken = '0;
      if (tick) begin
         if (tick_count != 16'hffff) tick_count = tick_count + 16'd1;
         if (tick_count >= limit) begin
            tick_count = '0;
            sample_pins({a, b});
         end
      end
      if (take) begin
         report.turns_taken = qdd_pkg::to_field(turn_count);
         turn_count = '0;
      end
      report.pending_now = qdd_pkg::to_field(turn_count);
   endtask

   always @(posedge clock) begin : watch
      turn_report_type predicted;
      turn_report_type oldest;
      if (reset) begin
         detent_size = 4'd4;
         tick_interval = 16'd1;
         primed = 1'b0;
         last_ab = 2'b00;
         step_sum = '0;
         turn_count = '0;
         tick_count = '0;
         expected_reports.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected response transaction: turns_taken %0d pending_now %0d",
                      rsp_mon.turns_taken, rsp_mon.pending_now);
               mismatch_count++;
            end else begin
               oldest = expected_reports.pop_front();
               if (rsp_mon.turns_taken !== oldest.turns_taken) begin
                  $error("turns_taken: expected %0d, got %0d",
                         oldest.turns_taken, rsp_mon.turns_taken);
                  mismatch_count++;
               end
               if (rsp_mon.pending_now !== oldest.pending_now) begin
                  $error("pending_now: expected %0d, got %0d",
                         oldest.pending_now, rsp_mon.pending_now);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_turn_report(req_mon.ms_tick, req_mon.level_a, req_mon.level_b,
                                req_mon.take_request, predicted);
            expected_reports.push_back(predicted);
         end
         if (csr_we) begin
            if (csr_index == qdd_pkg::CSR_STEPS_PER_DETENT) begin
               detent_size = csr_wdata[qdd_pkg::SPD_WIDTH-1:0];
            end else if (csr_index == qdd_pkg::CSR_SAMPLE_INTERVAL) begin
               tick_interval = csr_wdata[qdd_pkg::INTERVAL_WIDTH-1:0];
            end
         end
      end
      awaiting = expected_reports.size();
   end

endmodule

>>> tb/tb.sv
// testbench top for the quadrature detent decoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   logic clock;
   logic reset;
   logic csr_we;
   qdd_pkg::csr_index_type csr_index;
   logic [qdd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;
   int send_idle_pct;
   int stall_pct;
   int mismatches;
   int results_due;
   int unsigned cycle_count;
   logic [1:0] encoder_pos;

   qdd_req_if req_chan ();
   qdd_rsp_if rsp_chan ();

   quadrature_detent_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   qdd_turn_checker turn_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_chan),
      .rsp_mon   (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (mismatches),
      .awaiting  (results_due)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [1:0] gray_pins(input logic [1:0] pos);
      case (pos)
         2'd0: return 2'b00;
         2'd1: return 2'b10;
         2'd2: return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   task automatic send_item(input logic tick, input logic a, input logic b, input logic take);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ms_tick <= tick;
      req_chan.level_a <= a;
      req_chan.level_b <= b;
      req_chan.take_request <= take;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic turn_encoder(input int dir, input logic take);
      logic [1:0] pins;
      encoder_pos = encoder_pos + 2'(dir);
      pins = gray_pins(encoder_pos);
      send_item(1'b1, pins[1], pins[0], take);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   task automatic configure_decoder(input logic [qdd_pkg::SPD_WIDTH-1:0] spd,
                                    input logic [qdd_pkg::INTERVAL_WIDTH-1:0] interval);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= qdd_pkg::CSR_STEPS_PER_DETENT;
      csr_wdata <= qdd_pkg::CSR_DATA_WIDTH'(spd);
      @(negedge clock);
      csr_index <= qdd_pkg::CSR_SAMPLE_INTERVAL;
      csr_wdata <= qdd_pkg::CSR_DATA_WIDTH'(interval);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_burst(input int count);
      int dir;
      int r;
      logic [1:0] pins;
      logic tick;
      logic take;
      dir = 1;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 10) dir = $urandom_range(1) ? 1 : -1;
         if (r < 70) encoder_pos = encoder_pos + 2'(dir);
         else if (r < 80) encoder_pos = encoder_pos - 2'(dir);
         else if (r < 87) encoder_pos = encoder_pos + 2'd2;
         pins = gray_pins(encoder_pos);
         tick = ($urandom_range(99) < 85);
         take = ($urandom_range(99) < 6);
         if ($urandom_range(99) < 5) begin
            tick = 1'b0;
            pins = 2'($urandom_range(3));
         end
         send_item(tick, pins[1], pins[0], take);
      end
   endtask

   initial begin : stimulus
      logic [qdd_pkg::SPD_WIDTH-1:0] spd_set [8];
      logic [qdd_pkg::INTERVAL_WIDTH-1:0] interval_set [8];
      int idle_set [4];
      int stall_set [4];
      logic [1:0] pins;
      spd_set = '{4'd4, 4'd1, 4'd15, 4'd0, 4'd7, 4'd15, 4'd2, 4'd1};
      interval_set = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd3, 16'd1, 16'd5, 16'd2};
      idle_set = '{0, 68, 0, 13};
      stall_set = '{0, 0, 68, 13};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = qdd_pkg::CSR_STEPS_PER_DETENT;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.ms_tick = 1'b0;
      req_chan.level_a = 1'b0;
      req_chan.level_b = 1'b0;
      req_chan.take_request = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      encoder_pos = 2'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: prime, one forward detent, ignored levels, invalid jump, reverse detent
      send_item(1'b1, 1'b0, 1'b0, 1'b0);
      turn_encoder(1, 1'b0);
      turn_encoder(1, 1'b0);
      turn_encoder(1, 1'b0);
      turn_encoder(1, 1'b1);
      send_item(1'b0, 1'b1, 1'b1, 1'b1);
      send_item(1'b1, 1'b1, 1'b1, 1'b0);
      encoder_pos = 2'd2;
      turn_encoder(-1, 1'b0);
      turn_encoder(-1, 1'b0);
      turn_encoder(-1, 1'b0);
      turn_encoder(-1, 1'b0);
      send_item(1'b0, 1'b0, 1'b1, 1'b1);
      turn_encoder(1, 1'b1);
      send_item(1'b1, 1'b0, 1'b1, 1'b0);
      encoder_pos = 2'd3;

      // zero detent size and zero interval, forward run
      configure_decoder(4'd0, 16'd0);
      repeat (100) turn_encoder(1, 1'b0);
      turn_encoder(1, 1'b1);

      // reverse run
      configure_decoder(4'd1, 16'd1);
      repeat (100) turn_encoder(-1, 1'b0);
      turn_encoder(-1, 1'b1);

      // widest interval
      configure_decoder(4'd15, 16'hffff);
      repeat (200) begin
         pins = 2'($urandom_range(3));
         send_item(1'b1, pins[1], pins[0], ($urandom_range(99) == 0));
      end

      for (int phase = 0; phase < 4; phase++) begin
         for (int setting = 0; setting < 2; setting++) begin
            configure_decoder(spd_set[2 * phase + setting], interval_set[2 * phase + setting]);
            send_idle_pct = idle_set[phase];
            stall_pct = stall_set[phase];
            random_burst(130);
         end
      end

      drain_results();
      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
